// ===== src/mcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the cascade controller.
// No dependencies; the design files refer to this package by scoped names, the bench imports it.
package mcc_pkg;

  localparam int CMD_W      = 16;
  localparam int ST_W       = 32;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 34;
  localparam int PROD_W     = 50;
  localparam int SUM_W      = 52;
  localparam int RND_SHIFT  = 11;
  localparam int ACT_W      = SUM_W - RND_SHIFT;
  localparam int FF_SHIFT   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_P   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_DFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_P   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_P   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_D   = 3'd5;

  localparam logic [1:0] MODE_RATE = 2'd0;
  localparam logic [1:0] MODE_ATT  = 2'd1;
  localparam logic [1:0] MODE_VEL  = 2'd2;
  localparam logic [1:0] MODE_POS  = 2'd3;

  localparam logic signed [ACT_W-1:0] Q13_ZERO    = 0;
  localparam logic signed [ACT_W-1:0] Q13_ONE     = 8192;
  localparam logic signed [ACT_W-1:0] Q13_HALF_PI = 12868;
  localparam logic signed [ACT_W-1:0] Q13_PI      = 25736;
  localparam logic signed [ACT_W-1:0] Q13_TWO_PI  = 51472;
  localparam logic signed [SUM_W-1:0] RND_HALF    = 1024;

  typedef struct packed {
    logic [63:0]        command_word;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [47:0]        attitude_angles;
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] heading_rate;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] motor_left;
    logic signed [15:0] motor_front;
    logic signed [15:0] motor_right;
    logic signed [15:0] motor_back;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] att_p;
    logic [47:0] att_dff;
    logic [31:0] vel_p;
    logic [63:0] pos_p;
    logic [31:0] pos_d;
  } cfg_t;

  // state and command carried down the pipe
  typedef struct packed {
    logic signed [CMD_W-1:0] c0;
    logic signed [CMD_W-1:0] c1;
    logic signed [CMD_W-1:0] c2;
    logic signed [CMD_W-1:0] c3;
    logic signed [CMD_W-1:0] roll;
    logic signed [CMD_W-1:0] pitch;
    logic signed [ST_W-1:0]  vel_x;
    logic signed [ST_W-1:0]  vel_y;
    logic signed [ST_W-1:0]  vel_z;
    logic signed [ST_W-1:0]  roll_rate;
    logic signed [ST_W-1:0]  pitch_rate;
    logic signed [ST_W-1:0]  heading_rate;
  } carry_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] m0;
    logic signed [PROD_W-1:0] m1;
    logic signed [PROD_W-1:0] m2;
    logic signed [PROD_W-1:0] m3;
    logic signed [PROD_W-1:0] m4;
    logic signed [PROD_W-1:0] m5;
  } outer_prod_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] q0a;
    logic signed [PROD_W-1:0] q0b;
    logic signed [PROD_W-1:0] q1a;
    logic signed [PROD_W-1:0] q1b;
    logic signed [PROD_W-1:0] q2;
    logic signed [PROD_W-1:0] q3;
  } att_prod_t;

  function automatic logic signed [ACT_W-1:0] ext_act(input logic signed [CMD_W-1:0] v);
    return {{(ACT_W-CMD_W){v[CMD_W-1]}}, v};
  endfunction

  function automatic logic signed [ERR_W-1:0] ext_err16(input logic signed [CMD_W-1:0] v);
    return {{(ERR_W-CMD_W){v[CMD_W-1]}}, v};
  endfunction

  function automatic logic signed [ERR_W-1:0] ext_err32(input logic signed [ST_W-1:0] v);
    return {{(ERR_W-ST_W){v[ST_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [PROD_W-1:0] v);
    return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_gain(input logic signed [GAIN_W-1:0] v);
    return {{(SUM_W-GAIN_W){v[GAIN_W-1]}}, v};
  endfunction

  function automatic logic signed [ACT_W-1:0] clip(input logic signed [ACT_W-1:0] v,
                                                   input logic signed [ACT_W-1:0] lim_lo,
                                                   input logic signed [ACT_W-1:0] lim_hi);
    logic signed [ACT_W-1:0] r;
    if (v < lim_lo) begin
      r = lim_lo;
    end else if (v > lim_hi) begin
      r = lim_hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Q.24 to Q.13, round half up
  function automatic logic signed [ACT_W-1:0] to_q13(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] t;
    t = x + RND_HALF;
    return $signed(t[SUM_W-1:RND_SHIFT]);
  endfunction

endpackage

// ===== src/mcc_outer.sv =====
`timescale 1ns / 1ps
// Position / velocity stage: clip the command, form errors, multiply by gains.
// Two register stages; uses mcc_pkg.
module mcc_outer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  mcc_pkg::in_word_t    in_data,
  input  mcc_pkg::cfg_t        cfg,
  output logic                 prod_valid,
  output mcc_pkg::outer_prod_t prod,
  output mcc_pkg::carry_t      prod_carry
);

  logic signed [mcc_pkg::ACT_W-1:0] cl0, cl1, cl2, cl3;
  logic signed [mcc_pkg::ST_W-1:0]  x_sel, y_sel;
  logic signed [mcc_pkg::ERR_W-1:0] e0_nxt, e1_nxt, e2_nxt, e3_nxt;
  mcc_pkg::carry_t                  carry_nxt;

  logic                             v1_r;
  logic signed [mcc_pkg::ERR_W-1:0] e0_r, e1_r, e2_r, e3_r;
  mcc_pkg::carry_t                  carry1_r;

  logic signed [mcc_pkg::GAIN_W-1:0] g0, g1, g2, g3, gd0, gd1;
  mcc_pkg::outer_prod_t              prod_nxt;

  logic                 v2_r;
  mcc_pkg::outer_prod_t prod_r;
  mcc_pkg::carry_t      carry2_r;

  always_comb begin
    carry_nxt.c0           = $signed(in_data.command_word[15:0]);
    carry_nxt.c1           = $signed(in_data.command_word[31:16]);
    carry_nxt.c2           = $signed(in_data.command_word[47:32]);
    carry_nxt.c3           = $signed(in_data.command_word[63:48]);
    carry_nxt.roll         = $signed(in_data.attitude_angles[15:0]);
    carry_nxt.pitch        = $signed(in_data.attitude_angles[31:16]);
    carry_nxt.vel_x        = in_data.vel_x;
    carry_nxt.vel_y        = in_data.vel_y;
    carry_nxt.vel_z        = in_data.vel_z;
    carry_nxt.roll_rate    = in_data.roll_rate;
    carry_nxt.pitch_rate   = in_data.pitch_rate;
    carry_nxt.heading_rate = in_data.heading_rate;

    cl0 = mcc_pkg::clip(mcc_pkg::ext_act(carry_nxt.c0), -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);
    cl1 = mcc_pkg::clip(mcc_pkg::ext_act(carry_nxt.c1), -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);
    cl2 = mcc_pkg::clip(mcc_pkg::ext_act(carry_nxt.c2), -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);
    cl3 = mcc_pkg::clip(mcc_pkg::ext_act(carry_nxt.c3), -mcc_pkg::Q13_PI, mcc_pkg::Q13_PI);

    if (cfg.mode == mcc_pkg::MODE_VEL) begin
      x_sel = in_data.vel_x;
      y_sel = in_data.vel_y;
    end else begin
      x_sel = in_data.pos_x;
      y_sel = in_data.pos_y;
    end

    e0_nxt = ($signed(cl0[mcc_pkg::ERR_W-1:0]) <<< 3) - mcc_pkg::ext_err32(x_sel);
    e1_nxt = ($signed(cl1[mcc_pkg::ERR_W-1:0]) <<< 3) - mcc_pkg::ext_err32(y_sel);
    e2_nxt = ($signed(cl2[mcc_pkg::ERR_W-1:0]) <<< 3) - mcc_pkg::ext_err32(in_data.pos_z);
    e3_nxt = ($signed(cl3[mcc_pkg::ERR_W-1:0])
             - mcc_pkg::ext_err16($signed(in_data.attitude_angles[47:32]))) <<< 3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r     <= e0_nxt;
      e1_r     <= e1_nxt;
      e2_r     <= e2_nxt;
      e3_r     <= e3_nxt;
      carry1_r <= carry_nxt;
    end
  end

  always_comb begin
    if (cfg.mode == mcc_pkg::MODE_VEL) begin
      g0 = $signed(cfg.vel_p[15:0]);
      g1 = $signed(cfg.vel_p[31:16]);
    end else begin
      g0 = $signed(cfg.pos_p[15:0]);
      g1 = $signed(cfg.pos_p[31:16]);
    end
    g2  = $signed(cfg.pos_p[47:32]);
    g3  = $signed(cfg.pos_p[63:48]);
    gd0 = $signed(cfg.pos_d[15:0]);
    gd1 = $signed(cfg.pos_d[31:16]);

    prod_nxt.m0 = mcc_pkg::PROD_W'(g0) * mcc_pkg::PROD_W'(e0_r);
    prod_nxt.m1 = mcc_pkg::PROD_W'(g1) * mcc_pkg::PROD_W'(e1_r);
    prod_nxt.m2 = mcc_pkg::PROD_W'(g2) * mcc_pkg::PROD_W'(e2_r);
    prod_nxt.m3 = mcc_pkg::PROD_W'(g3) * mcc_pkg::PROD_W'(e3_r);
    prod_nxt.m4 = mcc_pkg::PROD_W'(gd0) * mcc_pkg::PROD_W'(carry1_r.vel_x);
    prod_nxt.m5 = mcc_pkg::PROD_W'(gd1) * mcc_pkg::PROD_W'(carry1_r.vel_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      carry2_r <= carry1_r;
    end
  end

  assign prod_valid = v2_r;
  assign prod       = prod_r;
  assign prod_carry = carry2_r;

endmodule

// ===== src/mcc_att.sv =====
`timescale 1ns / 1ps
// Attitude stage: round the outer action, pick the entry point, clip, form
// errors and multiply by attitude gains. Two register stages; uses mcc_pkg.
module mcc_att (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 prod_valid,
  input  mcc_pkg::outer_prod_t prod,
  input  mcc_pkg::carry_t      prod_carry,
  input  mcc_pkg::cfg_t        cfg,
  output logic                 att_valid,
  output mcc_pkg::att_prod_t   att,
  output mcc_pkg::carry_t      att_carry
);

  logic signed [mcc_pkg::SUM_W-1:0] sx, sy;
  logic signed [mcc_pkg::ACT_W-1:0] a0, a1, a2, a3;
  logic signed [mcc_pkg::ACT_W-1:0] k0, k1, k2, k3;
  logic signed [mcc_pkg::ERR_W-1:0] f0_nxt, f1_nxt, f2_nxt, f3_nxt;

  logic                             v3_r;
  logic signed [mcc_pkg::ERR_W-1:0] f0_r, f1_r, f2_r, f3_r;
  mcc_pkg::carry_t                  carry3_r;

  logic signed [mcc_pkg::GAIN_W-1:0] pr, pp, py, pc, dr, dp;
  mcc_pkg::att_prod_t                att_nxt;

  logic               v4_r;
  mcc_pkg::att_prod_t att_r;
  mcc_pkg::carry_t    carry4_r;

  always_comb begin
    sx = mcc_pkg::ext_sum(prod.m0) - mcc_pkg::ext_sum(prod.m4);
    sy = mcc_pkg::ext_sum(prod.m5) - mcc_pkg::ext_sum(prod.m1);
    unique case (cfg.mode)
      mcc_pkg::MODE_RATE, mcc_pkg::MODE_ATT: begin
        a0 = mcc_pkg::ext_act(prod_carry.c0);
        a1 = mcc_pkg::ext_act(prod_carry.c1);
        a2 = mcc_pkg::ext_act(prod_carry.c2);
        a3 = mcc_pkg::ext_act(prod_carry.c3);
      end
      mcc_pkg::MODE_VEL: begin
        a0 = mcc_pkg::to_q13(-mcc_pkg::ext_sum(prod.m1));
        a1 = mcc_pkg::to_q13(mcc_pkg::ext_sum(prod.m0));
        a2 = mcc_pkg::ext_act(prod_carry.c3);
        a3 = mcc_pkg::ext_act(prod_carry.c2);
      end
      mcc_pkg::MODE_POS: begin
        a0 = mcc_pkg::to_q13(sy);
        a1 = mcc_pkg::to_q13(sx);
        a2 = mcc_pkg::to_q13(mcc_pkg::ext_sum(prod.m3));
        a3 = mcc_pkg::to_q13(mcc_pkg::ext_sum(prod.m2));
      end
      default: begin
        a0 = mcc_pkg::ext_act(prod_carry.c0);
        a1 = mcc_pkg::ext_act(prod_carry.c1);
        a2 = mcc_pkg::ext_act(prod_carry.c2);
        a3 = mcc_pkg::ext_act(prod_carry.c3);
      end
    endcase

    k0 = mcc_pkg::clip(a0, -mcc_pkg::Q13_HALF_PI, mcc_pkg::Q13_HALF_PI);
    k1 = mcc_pkg::clip(a1, -mcc_pkg::Q13_HALF_PI, mcc_pkg::Q13_HALF_PI);
    k2 = mcc_pkg::clip(a2, -mcc_pkg::Q13_TWO_PI, mcc_pkg::Q13_TWO_PI);
    k3 = mcc_pkg::clip(a3, -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);

    f0_nxt = ($signed(k0[mcc_pkg::ERR_W-1:0]) - mcc_pkg::ext_err16(prod_carry.roll)) <<< 3;
    f1_nxt = ($signed(k1[mcc_pkg::ERR_W-1:0]) - mcc_pkg::ext_err16(prod_carry.pitch)) <<< 3;
    f2_nxt = ($signed(k2[mcc_pkg::ERR_W-1:0]) <<< 3)
             - mcc_pkg::ext_err32(prod_carry.heading_rate);
    f3_nxt = ($signed(k3[mcc_pkg::ERR_W-1:0]) <<< 3) - mcc_pkg::ext_err32(prod_carry.vel_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r     <= f0_nxt;
      f1_r     <= f1_nxt;
      f2_r     <= f2_nxt;
      f3_r     <= f3_nxt;
      carry3_r <= prod_carry;
    end
  end

  always_comb begin
    pr = $signed(cfg.att_p[15:0]);
    pp = $signed(cfg.att_p[31:16]);
    py = $signed(cfg.att_p[47:32]);
    pc = $signed(cfg.att_p[63:48]);
    dr = $signed(cfg.att_dff[15:0]);
    dp = $signed(cfg.att_dff[31:16]);

    att_nxt.q0a = mcc_pkg::PROD_W'(pr) * mcc_pkg::PROD_W'(f0_r);
    att_nxt.q0b = mcc_pkg::PROD_W'(dr) * mcc_pkg::PROD_W'(carry3_r.roll_rate);
    att_nxt.q1a = mcc_pkg::PROD_W'(pp) * mcc_pkg::PROD_W'(f1_r);
    att_nxt.q1b = mcc_pkg::PROD_W'(dp) * mcc_pkg::PROD_W'(carry3_r.pitch_rate);
    att_nxt.q2  = mcc_pkg::PROD_W'(py) * mcc_pkg::PROD_W'(f2_r);
    att_nxt.q3  = mcc_pkg::PROD_W'(pc) * mcc_pkg::PROD_W'(f3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      att_r    <= att_nxt;
      carry4_r <= carry3_r;
    end
  end

  assign att_valid = v4_r;
  assign att       = att_r;
  assign att_carry = carry4_r;

endmodule

// ===== src/mcc_mix.sv =====
`timescale 1ns / 1ps
// Rate stage: sum and round the attitude terms (rate mode takes the command), clip and mix into four motors.
// Holds the output register; uses mcc_pkg.
module mcc_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               att_valid,
  input  mcc_pkg::att_prod_t att,
  input  mcc_pkg::carry_t    att_carry,
  input  mcc_pkg::cfg_t      cfg,
  output logic               out_valid,
  output mcc_pkg::out_word_t out_data
);

  logic signed [mcc_pkg::SUM_W-1:0] ff;
  logic signed [mcc_pkg::ACT_W-1:0] d0, d1, d2, d3;
  logic signed [mcc_pkg::ACT_W-1:0] r, p, y, t;
  logic signed [15:0]               r16, p16, y16, t16;
  mcc_pkg::out_word_t               out_nxt;

  logic               out_valid_r;
  mcc_pkg::out_word_t out_data_r;

  always_comb begin
    ff = mcc_pkg::ext_gain($signed(cfg.att_dff[47:32])) <<< mcc_pkg::FF_SHIFT;
    if (cfg.mode == mcc_pkg::MODE_RATE) begin
      d0 = mcc_pkg::ext_act(att_carry.c0);
      d1 = mcc_pkg::ext_act(att_carry.c1);
      d2 = mcc_pkg::ext_act(att_carry.c2);
      d3 = mcc_pkg::ext_act(att_carry.c3);
    end else begin
      d0 = mcc_pkg::to_q13(mcc_pkg::ext_sum(att.q0a) - mcc_pkg::ext_sum(att.q0b));
      d1 = mcc_pkg::to_q13(mcc_pkg::ext_sum(att.q1a) - mcc_pkg::ext_sum(att.q1b));
      d2 = mcc_pkg::to_q13(mcc_pkg::ext_sum(att.q2));
      d3 = mcc_pkg::to_q13(mcc_pkg::ext_sum(att.q3) + ff);
    end

    r = mcc_pkg::clip(d0, -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);
    p = mcc_pkg::clip(d1, -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);
    y = mcc_pkg::clip(d2, -mcc_pkg::Q13_ONE, mcc_pkg::Q13_ONE);
    t = mcc_pkg::clip(d3, mcc_pkg::Q13_ZERO, mcc_pkg::Q13_ONE);

    r16 = $signed(r[15:0]);
    p16 = $signed(p[15:0]);
    y16 = $signed(y[15:0]);
    t16 = $signed(t[15:0]);

    out_nxt.motor_left  = r16 + y16 + t16;
    out_nxt.motor_front = p16 - y16 + t16;
    out_nxt.motor_right = -r16 + y16 + t16;
    out_nxt.motor_back  = -p16 - y16 + t16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= att_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/multirotor_cascade_controller_unit.sv =====
`timescale 1ns / 1ps
// Cascaded multirotor controller: config registers, pipeline control, stages.
// Throughput: one word per cycle when the output is not held.
// The five stages advance together; a held output word stalls the whole pipe.
// Synchronous active-low reset clears all valid bits and every config register.
// Depends on mcc_pkg, mcc_outer, mcc_att and mcc_mix.
module multirotor_cascade_controller_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mcc_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mcc_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mcc_pkg::cfg_t        cfg_r;
  logic                 en;
  logic                 prod_valid;
  mcc_pkg::outer_prod_t prod;
  mcc_pkg::carry_t      prod_carry;
  logic                 att_valid;
  mcc_pkg::att_prod_t   att;
  mcc_pkg::carry_t      att_carry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcc_pkg::REG_MODE:    cfg_r.mode    <= cfg_data[1:0];
        mcc_pkg::REG_ATT_P:   cfg_r.att_p   <= cfg_data;
        mcc_pkg::REG_ATT_DFF: cfg_r.att_dff <= cfg_data[47:0];
        mcc_pkg::REG_VEL_P:   cfg_r.vel_p   <= cfg_data[31:0];
        mcc_pkg::REG_POS_P:   cfg_r.pos_p   <= cfg_data;
        mcc_pkg::REG_POS_D:   cfg_r.pos_d   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // advance when the output register is empty or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  mcc_outer u_outer (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_carry (prod_carry)
  );

  mcc_att u_att (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_carry (prod_carry),
    .cfg        (cfg_r),
    .att_valid  (att_valid),
    .att        (att),
    .att_carry  (att_carry)
  );

  mcc_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .att_valid  (att_valid),
    .att        (att),
    .att_carry  (att_carry),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// ===== tb/tb_multirotor_cascade_controller_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the cascade controller: bursty sender, stalling receiver,
// and a scoreboard class that predicts the four motor commands per accepted word.
// Depends on mcc_pkg and multirotor_cascade_controller_unit.
module tb_multirotor_cascade_controller_unit;
  import mcc_pkg::*;

  localparam longint LIM_ONE     = 8192;
  localparam longint LIM_HALF_PI = 12868;
  localparam longint LIM_PI      = 25736;
  localparam longint LIM_TWO_PI  = 51472;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 158;

  class motor_scoreboard;
    cfg_t      regs;
    out_word_t pending_motors[$];
    int        mismatches;

    function new();
      regs = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:    regs.mode    = data[1:0];
        REG_ATT_P:   regs.att_p   = data;
        REG_ATT_DFF: regs.att_dff = data[47:0];
        REG_VEL_P:   regs.vel_p   = data[31:0];
        REG_POS_P:   regs.pos_p   = data;
        REG_POS_D:   regs.pos_d   = data[31:0];
        default: ;
      endcase
    endfunction

    function longint lane(logic [63:0] v, int k);
      return longint'($signed(v[16*k +: 16]));
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q.24 to Q.13, round half up
    function longint round_q13(longint q24);
      return (q24 + 64'sd1024) >>> 11;
    endfunction

    function out_word_t mix_motors(longint a0, longint a1, longint a2, longint a3);
      longint r, p, y, t;
      out_word_t m;
      r = clamp(a0, -LIM_ONE, LIM_ONE);
      p = clamp(a1, -LIM_ONE, LIM_ONE);
      y = clamp(a2, -LIM_ONE, LIM_ONE);
      t = clamp(a3, 0, LIM_ONE);
      m.motor_left  = 16'(r + y + t);
      m.motor_front = 16'(p - y + t);
      m.motor_right = 16'(-r + y + t);
      m.motor_back  = 16'(-p - y + t);
      return m;
    endfunction

    function out_word_t attitude_motors(longint a0, longint a1, longint a2, longint a3,
                                        in_word_t w);
      longint c0, c1, c2, c3, q0, q1, q2, q3;
      c0 = clamp(a0, -LIM_HALF_PI, LIM_HALF_PI);
      c1 = clamp(a1, -LIM_HALF_PI, LIM_HALF_PI);
      c2 = clamp(a2, -LIM_TWO_PI, LIM_TWO_PI);
      c3 = clamp(a3, -LIM_ONE, LIM_ONE);
      q0 = lane(regs.att_p, 0) * ((c0 - lane(w.attitude_angles, 0)) * 8)
         - lane(regs.att_dff, 0) * longint'(w.roll_rate);
      q1 = lane(regs.att_p, 1) * ((c1 - lane(w.attitude_angles, 1)) * 8)
         - lane(regs.att_dff, 1) * longint'(w.pitch_rate);
      q2 = lane(regs.att_p, 2) * (c2 * 8 - longint'(w.heading_rate));
      q3 = lane(regs.att_p, 3) * (c3 * 8 - longint'(w.vel_z))
         + lane(regs.att_dff, 2) * 65536;
      return mix_motors(round_q13(q0), round_q13(q1), round_q13(q2), round_q13(q3));
    endfunction

    function out_word_t predict_motors(in_word_t w);
      longint c0, c1, c2, c3, ex, ey, px, py, pz, pw, dx, dy;
      c0 = lane(w.command_word, 0);
      c1 = lane(w.command_word, 1);
      c2 = lane(w.command_word, 2);
      c3 = lane(w.command_word, 3);
      case (regs.mode)
        MODE_RATE: return mix_motors(c0, c1, c2, c3);
        MODE_ATT:  return attitude_motors(c0, c1, c2, c3, w);
        MODE_VEL: begin
          ex = lane(regs.vel_p, 0) * (clamp(c0, -LIM_ONE, LIM_ONE) * 8 - longint'(w.vel_x));
          ey = lane(regs.vel_p, 1) * (clamp(c1, -LIM_ONE, LIM_ONE) * 8 - longint'(w.vel_y));
          return attitude_motors(round_q13(-ey), round_q13(ex), c3, c2, w);
        end
        default: begin
          px = lane(regs.pos_p, 0) * (clamp(c0, -LIM_ONE, LIM_ONE) * 8 - longint'(w.pos_x));
          py = lane(regs.pos_p, 1) * (clamp(c1, -LIM_ONE, LIM_ONE) * 8 - longint'(w.pos_y));
          pz = lane(regs.pos_p, 2) * (clamp(c2, -LIM_ONE, LIM_ONE) * 8 - longint'(w.pos_z));
          pw = lane(regs.pos_p, 3)
             * ((clamp(c3, -LIM_PI, LIM_PI) - lane(w.attitude_angles, 2)) * 8);
          dx = -lane(regs.pos_d, 0) * longint'(w.vel_x);
          dy = -lane(regs.pos_d, 1) * longint'(w.vel_y);
          return attitude_motors(round_q13(-py - dy), round_q13(px + dx),
                                 round_q13(pw), round_q13(pz), w);
        end
      endcase
    endfunction

    task note_word(in_word_t w);
      pending_motors = {pending_motors, predict_motors(w)};
    endtask

    task report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending_motors.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      want = pending_motors.pop_front();
      check_field("motor_left", got.motor_left, want.motor_left);
      check_field("motor_front", got.motor_front, want.motor_front);
      check_field("motor_right", got.motor_right, want.motor_right);
      check_field("motor_back", got.motor_back, want.motor_back);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  motor_scoreboard sb;
  int burst_left = 0;
  int stall_left = 0;
  int stall_pct  = 0;

  multirotor_cascade_controller_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL multirotor_cascade_controller_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  // receiver: stretches of varying stall density, some with none
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(10, 80);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_left--;
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [15:0] random_q13();
    logic [15:0] corner [9] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h2000,
                                16'hE000, 16'h3244, 16'hCDBC, 16'h6488};
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return corner[$urandom_range(8)];
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] random_q16();
    logic [31:0] corner [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    case ($urandom_range(7))
      0: return $urandom;
      1: return corner[$urandom_range(3)];
      default: return 32'($urandom_range(1 << 19) - (1 << 18));
    endcase
  endfunction

  function automatic logic [15:0] random_gain(int phase);
    logic [15:0] corner [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFF00};
    if (phase == 0) return 16'h7FFF;
    if (phase == 1) return 16'h8000;
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: return corner[$urandom_range(4)];
      default: return 16'($urandom_range(2048) - 1024);
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.command_word    = {random_q13(), random_q13(), random_q13(), random_q13()};
    w.pos_x           = random_q16();
    w.pos_y           = random_q16();
    w.pos_z           = random_q16();
    w.vel_x           = random_q16();
    w.vel_y           = random_q16();
    w.vel_z           = random_q16();
    w.attitude_angles = {random_q13(), random_q13(), random_q13()};
    w.roll_rate       = random_q16();
    w.pitch_rate      = random_q16();
    w.heading_rate    = random_q16();
    return w;
  endfunction

  function automatic in_word_t uniform_word(logic [15:0] c, logic [31:0] s);
    in_word_t w;
    w.command_word    = {4{c}};
    w.attitude_angles = {3{c}};
    w.pos_x = s;  w.pos_y = s;  w.pos_z = s;
    w.vel_x = s;  w.vel_y = s;  w.vel_z = s;
    w.roll_rate = s;  w.pitch_rate = s;  w.heading_rate = s;
    return w;
  endfunction

  task automatic push_word(in_word_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_motors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.load_reg(idx, data);
  endtask

  task automatic configure_phase(int phase, logic [1:0] mode);
    idle_sender();
    wait_drained();
    write_reg(REG_ATT_P, {random_gain(phase), random_gain(phase),
                          random_gain(phase), random_gain(phase)});
    write_reg(REG_ATT_DFF, {16'($urandom), random_gain(phase), random_gain(phase),
                            random_gain(phase)});
    write_reg(REG_VEL_P, {$urandom, random_gain(phase), random_gain(phase)});
    write_reg(REG_POS_P, {random_gain(phase), random_gain(phase),
                          random_gain(phase), random_gain(phase)});
    write_reg(REG_POS_D, {$urandom, random_gain(phase), random_gain(phase)});
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_MODE, {$urandom, 30'($urandom), mode});
  endtask

  initial begin
    logic [1:0] mode_order [4] = '{MODE_RATE, MODE_ATT, MODE_VEL, MODE_POS};
    in_word_t w;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // rate entry with reset registers
    push_word(uniform_word(16'h0000, 32'h0));
    push_word(uniform_word(16'h7FFF, 32'h7FFF_FFFF));
    push_word(uniform_word(16'h8000, 32'h8000_0000));
    push_word(uniform_word(16'hFFFF, 32'hFFFF_FFFF));
    w = uniform_word(16'h0, 32'h0);
    w.command_word = {16'h2001, 16'hDFFF, 16'h2000, 16'hE000};
    push_word(w);
    w.command_word = {16'hFFFF, 16'h1FFF, 16'hE001, 16'h1FFF};
    push_word(w);

    // attitude entry; oversized values and spare indexes
    idle_sender();
    wait_drained();
    write_reg(REG_ATT_P, {4{16'h7FFF}});
    write_reg(REG_ATT_DFF, 64'hDEAD_0100_8000_7FFF);
    write_reg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MODE, 64'hA5A5_0000_0000_0000 | 64'(MODE_ATT));
    push_word(uniform_word(16'h0000, 32'h0));
    push_word(uniform_word(16'h7FFF, 32'h7FFF_FFFF));
    push_word(uniform_word(16'h8000, 32'h8000_0000));
    w = uniform_word(16'h0, 32'h0001_0000);
    w.command_word = {16'h2000, 16'h3244, 16'hCDBB, 16'h3245};
    push_word(w);
    push_word(random_word());

    // velocity entry
    idle_sender();
    wait_drained();
    write_reg(REG_ATT_P, 64'h0100_0200_0400_0800);
    write_reg(REG_VEL_P, 64'hFFFF_FFFF_8000_7FFF);
    write_reg(REG_MODE, 64'(MODE_VEL));
    push_word(uniform_word(16'h7FFF, 32'h7FFF_FFFF));
    push_word(uniform_word(16'h8000, 32'h8000_0000));
    push_word(random_word());
    push_word(random_word());

    // position entry; large yaw error overruns the turn rate limit
    idle_sender();
    wait_drained();
    write_reg(REG_POS_P, 64'h7FFF_0200_8000_7FFF);
    write_reg(REG_POS_D, 64'h1234_5678_8000_7FFF);
    write_reg(REG_MODE, 64'(MODE_POS));
    w = uniform_word(16'h0, 32'h0);
    w.command_word[63:48]    = 16'h7FFF;
    w.attitude_angles[47:32] = 16'h8000;
    push_word(w);
    w.command_word[63:48]    = 16'h8000;
    w.attitude_angles[47:32] = 16'h7FFF;
    push_word(w);
    push_word(uniform_word(16'h0000, 32'h0));
    push_word(uniform_word(16'h7FFF, 32'h7FFF_FFFF));
    push_word(uniform_word(16'h8000, 32'h8000_0000));
    push_word(random_word());

    for (int phase = 0; phase < PHASES; phase++) begin
      configure_phase(phase, mode_order[phase % 4]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 6 && n == PHASE_WORDS / 2) begin
          // hold until the pipe has emptied
          idle_sender();
          while (sb.pending_motors.size() != 0) @(posedge clk);
        end
        push_word(random_word());
      end
    end

    idle_sender();
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS multirotor_cascade_controller_unit");
    end else begin
      $display("FAIL multirotor_cascade_controller_unit");
    end
    $finish;
  end

endmodule
